### rtl/core/rusi_pkg.sv
// shared constants for the ray and unit sphere intersection pipeline
`default_nettype none

package rusi_pkg;

    // default number format of every coordinate
    localparam int DEF_WORD_BITS = 32;
    localparam int DEF_FRAC_BITS = 16;

    // multiplier operand slice handled per pipeline stage
    localparam int MUL_CHUNK = 16;

    // bit positions of the result flags in m_tuser
    localparam int USER_HIT   = 0;
    localparam int USER_ENTER = 1;
    localparam int USER_SAT   = 2;
    localparam int USER_BITS  = 3;

endpackage

`default_nettype wire

### rtl/core/ray_unit_sphere_intersect.sv
// ray against unit sphere: the depth is set by the root pipeline (one bit per stage over the
// discriminant) and the divider (an overflow check stage, then one quotient bit per stage).
// one item per cycle while s_tready is high; an output register plus skid slot keeps
// input accepted while one result waits, and s_tready drops once the skid slot is full.
// reset clears all valid bits only.
`default_nettype none

module ray_unit_sphere_intersect #(
    parameter int WORD_BITS = rusi_pkg::DEF_WORD_BITS,
    parameter int FRAC_BITS = rusi_pkg::DEF_FRAC_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // dir_x, dir_y, dir_z, org_x, org_y, org_z, zero fill
    input  logic [((6*WORD_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // ray_param, hit_distance, point_x, point_y, point_z, zero fill
    output logic [((5*WORD_BITS+7)/8)*8-1:0]      m_tdata,
    // hit, entering, saturated
    output logic [rusi_pkg::USER_BITS-1:0]        m_tuser
);

    import rusi_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int AW  = 2 * W;
    localparam int BW  = 2 * W + 1;
    localparam int DSW = 4 * W + 2;
    localparam int SQW = 2 * W + 1;
    localparam int NW  = 2 * W + 3;
    localparam int QN  = 2 * W + 2 + F;
    localparam int PSW = 2 * W - F + 1;
    localparam int DWD = 2 * W - F;
    localparam int OTD = ((5 * W + 7) / 8) * 8;

    localparam logic signed [BW-1:0] ONE_SQ  = BW'(1) << (2 * F);
    localparam logic [W-1:0]         W_MAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]         W_MIN   = {1'b1, {(W-1){1'b0}}};

    typedef logic [2:0][W-1:0] vec_t;

    typedef struct packed {
        vec_t          k;
        vec_t          l;
        logic [AW-1:0] a;
        logic [AW-1:0] bmag;
        logic          bneg;
        logic          cneg;
        logic          azero;
    } mside_t;

    typedef struct packed {
        vec_t          k;
        vec_t          l;
        logic [AW-1:0] a;
        logic [AW-1:0] bmag;
        logic          bneg;
        logic          miss;
    } qside_t;

    typedef struct packed {
        vec_t         k;
        vec_t         l;
        logic [W-1:0] r;
        logic         enter;
        logic         miss;
    } dside_t;

    // clip a signed value into the word range, flag in the top bit
    function automatic logic [W:0] clip_word(input logic signed [PSW-1:0] v);
        logic [W:0] res;
        if (v[PSW-1:W-1] == {(PSW-W+1){v[PSW-1]}})
            res = {1'b0, v[W-1:0]};
        else if (v[PSW-1])
            res = {1'b1, W_MIN};
        else
            res = {1'b1, W_MAX};
        return res;
    endfunction

    logic en;

    // ---------------- stage 1: nine products ----------------
    logic                  st1_v_reg;
    logic signed [AW-1:0]  kk_reg [3];
    logic signed [AW-1:0]  kl_reg [3];
    logic signed [AW-1:0]  ll_reg [3];
    vec_t                  k1_reg;
    vec_t                  l1_reg;
    vec_t                  dir_in;
    vec_t                  org_in;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dir_in[i] = s_tdata[i*W +: W];
            org_in[i] = s_tdata[(3+i)*W +: W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st1_v_reg <= 1'b0;
        else if (en)
            st1_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                kk_reg[i] <= $signed(dir_in[i]) * $signed(dir_in[i]);
                kl_reg[i] <= $signed(dir_in[i]) * $signed(org_in[i]);
                ll_reg[i] <= $signed(org_in[i]) * $signed(org_in[i]);
            end
            k1_reg <= dir_in;
            l1_reg <= org_in;
        end
    end

    // ---------------- stage 2: dot products ----------------
    logic                  st2_v_reg;
    logic [AW-1:0]         a2_reg;
    logic signed [BW-1:0]  b2_reg;
    logic signed [BW-1:0]  c2_reg;
    vec_t                  k2_reg;
    vec_t                  l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st2_v_reg <= 1'b0;
        else if (en)
            st2_v_reg <= st1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_reg <= AW'(kk_reg[0]) + AW'(kk_reg[1]) + AW'(kk_reg[2]);
            b2_reg <= BW'(kl_reg[0]) + BW'(kl_reg[1]) + BW'(kl_reg[2]);
            c2_reg <= BW'(ll_reg[0]) + BW'(ll_reg[1]) + BW'(ll_reg[2]) - ONE_SQ;
            k2_reg <= k1_reg;
            l2_reg <= l1_reg;
        end
    end

    // ---------------- stage 3: magnitudes for the multipliers ----------------
    logic                  st3_v_reg;
    mside_t                ms3_reg;
    logic [AW-1:0]         cmag3_reg;
    logic signed [BW-1:0]  b_neg_val;
    logic signed [BW-1:0]  c_neg_val;

    assign b_neg_val = -b2_reg;
    assign c_neg_val = -c2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st3_v_reg <= 1'b0;
        else if (en)
            st3_v_reg <= st2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ms3_reg.k     <= k2_reg;
            ms3_reg.l     <= l2_reg;
            ms3_reg.a     <= a2_reg;
            ms3_reg.bmag  <= b2_reg[BW-1] ? b_neg_val[AW-1:0] : b2_reg[AW-1:0];
            ms3_reg.bneg  <= b2_reg[BW-1];
            ms3_reg.cneg  <= c2_reg[BW-1];
            ms3_reg.azero <= (a2_reg == '0);
            cmag3_reg     <= c2_reg[BW-1] ? c_neg_val[AW-1:0] : c2_reg[AW-1:0];
        end
    end

    // ---------------- b*b and a*c ----------------
    logic                 mul_v;
    logic [2*AW-1:0]      bb;
    logic [2*AW-1:0]      ac;
    mside_t               ms_out;

    rusi_mul #(
        .XW         (AW),
        .YW         (AW),
        .CHUNK_BITS (MUL_CHUNK),
        .SIDE_BITS  ($bits(mside_t))
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (st3_v_reg),
        .x0        (ms3_reg.bmag),
        .y0        (ms3_reg.bmag),
        .x1        (ms3_reg.a),
        .y1        (cmag3_reg),
        .in_side   (ms3_reg),
        .out_valid (mul_v),
        .p0        (bb),
        .p1        (ac),
        .out_side  (ms_out)
    );

    // ---------------- stage 4: discriminant ----------------
    logic                  st4_v_reg;
    logic signed [DSW-1:0] disc4_reg;
    mside_t                ms4_reg;
    logic signed [DSW-1:0] bb_s;
    logic signed [DSW-1:0] ac_s;
    qside_t                qs_in;

    assign bb_s = $signed(DSW'(bb));
    assign ac_s = $signed(DSW'(ac));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st4_v_reg <= 1'b0;
        else if (en)
            st4_v_reg <= mul_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            disc4_reg <= ms_out.cneg ? bb_s + ac_s : bb_s - ac_s;
            ms4_reg   <= ms_out;
        end
    end

    // negative discriminant or zero direction is a miss
    always_comb
    begin
        qs_in.k    = ms4_reg.k;
        qs_in.l    = ms4_reg.l;
        qs_in.a    = ms4_reg.a;
        qs_in.bmag = ms4_reg.bmag;
        qs_in.bneg = ms4_reg.bneg;
        qs_in.miss = ms4_reg.azero | disc4_reg[DSW-1];
    end

    // ---------------- sqrt(disc) and sqrt(a) ----------------
    logic             sq_v;
    logic [SQW-1:0]   s_root;
    logic [W-1:0]     a_root;
    qside_t           qs_out;

    rusi_sqrt #(
        .RW0       (DSW - 1),
        .RW1       (AW),
        .SIDE_BITS ($bits(qside_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (st4_v_reg),
        .rad0      (disc4_reg[DSW-2:0]),
        .rad1      (ms4_reg.a),
        .in_side   (qs_in),
        .out_valid (sq_v),
        .root0     (s_root),
        .root1     (a_root),
        .out_side  (qs_out)
    );

    // ---------------- stage 5: root numerators ----------------
    logic                 st5_v_reg;
    logic signed [NW-1:0] n1_reg;
    logic signed [NW-1:0] n2_reg;
    dside_t               ds5_reg;
    logic [AW-1:0]        a5_reg;
    logic signed [NW-1:0] bm_s;
    logic signed [NW-1:0] s_s;
    logic signed [NW-1:0] nb;

    always_comb
    begin
        bm_s = $signed(NW'(qs_out.bmag));
        s_s  = $signed(NW'(s_root));
        nb   = qs_out.bneg ? bm_s : -bm_s;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st5_v_reg <= 1'b0;
        else if (en)
            st5_v_reg <= sq_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg        <= nb + s_s;
            n2_reg        <= nb - s_s;
            a5_reg        <= qs_out.a;
            ds5_reg.k     <= qs_out.k;
            ds5_reg.l     <= qs_out.l;
            ds5_reg.r     <= a_root;
            ds5_reg.enter <= 1'b0;
            ds5_reg.miss  <= qs_out.miss;
        end
    end

    // ---------------- stage 6: pick the nearest positive root ----------------
    logic            st6_v_reg;
    logic [QN-1:0]   num6_reg;
    logic [AW-1:0]   a6_reg;
    dside_t          ds6_reg;
    logic [QN-1:0]   num1;
    logic [QN-1:0]   num2;
    logic            ok1;
    logic            ok2;

    always_comb
    begin
        num1 = {n1_reg[NW-2:0], {F{1'b0}}};
        num2 = {n2_reg[NW-2:0], {F{1'b0}}};
        ok1  = !n1_reg[NW-1] && (num1 >= QN'(a5_reg));
        ok2  = !n2_reg[NW-1] && (num2 >= QN'(a5_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st6_v_reg <= 1'b0;
        else if (en)
            st6_v_reg <= st5_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num6_reg      <= ok2 ? num2 : num1;
            a6_reg        <= a5_reg;
            ds6_reg.k     <= ds5_reg.k;
            ds6_reg.l     <= ds5_reg.l;
            ds6_reg.r     <= ds5_reg.r;
            ds6_reg.enter <= ok2;
            ds6_reg.miss  <= ds5_reg.miss | !(ok1 | ok2);
        end
    end

    // ---------------- t = num / a ----------------
    logic          dv_v;
    logic [W-2:0]  quo;
    logic          quo_ovf;
    dside_t        ds_out;

    rusi_div #(
        .NUMW      (QN),
        .DENW      (AW),
        .QB        (W - 1),
        .SIDE_BITS ($bits(dside_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (st6_v_reg),
        .num       (num6_reg),
        .den       (a6_reg),
        .in_side   (ds6_reg),
        .out_valid (dv_v),
        .quo       (quo),
        .ovf       (quo_ovf),
        .out_side  (ds_out)
    );

    // ---------------- stage 7: scale direction and length by t ----------------
    logic                 st7_v_reg;
    logic signed [AW-1:0] pk_reg [3];
    logic [AW-1:0]        dprod_reg;
    logic [W-1:0]         t7_reg;
    logic                 sat7_reg;
    logic                 enter7_reg;
    logic                 miss7_reg;
    vec_t                 l7_reg;
    logic [W-1:0]         t_word;

    assign t_word = {1'b0, quo_ovf ? {(W-1){1'b1}} : quo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st7_v_reg <= 1'b0;
        else if (en)
            st7_v_reg <= dv_v;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                pk_reg[i] <= $signed(ds_out.k[i]) * $signed(t_word);
            dprod_reg  <= t_word * ds_out.r;
            t7_reg     <= t_word;
            sat7_reg   <= quo_ovf;
            enter7_reg <= ds_out.enter;
            miss7_reg  <= ds_out.miss;
            l7_reg     <= ds_out.l;
        end
    end

    // ---------------- stage 8: hit point, distance, clipping ----------------
    logic                  pv_reg;
    logic [OTD-1:0]        pdata_reg;
    logic [USER_BITS-1:0]  puser_reg;
    logic [OTD-1:0]        pdata_next;
    logic [USER_BITS-1:0]  puser_next;
    logic signed [AW-1:0]  pk_sh   [3];
    logic signed [PSW-1:0] pt_sum  [3];
    logic [W:0]            pt_clip [3];
    logic [DWD-1:0]        dist_sh;
    logic [W-1:0]          dist_w;
    logic                  dist_sat;
    logic                  any_sat;

    always_comb
    begin
        any_sat = sat7_reg;
        for (int i = 0; i < 3; i++)
        begin
            pk_sh[i]   = pk_reg[i] >>> F;
            pt_sum[i]  = $signed(pk_sh[i][PSW-1:0]) + PSW'($signed(l7_reg[i]));
            pt_clip[i] = clip_word(pt_sum[i]);
            any_sat    = any_sat | pt_clip[i][W];
        end
        dist_sh  = dprod_reg[AW-1:F];
        dist_sat = |dist_sh[DWD-1:W-1];
        dist_w   = dist_sat ? W_MAX : dist_sh[W-1:0];
        any_sat  = any_sat | dist_sat;

        pdata_next = '0;
        puser_next = '0;
        if (!miss7_reg)
        begin
            pdata_next[0*W +: W]   = t7_reg;
            pdata_next[1*W +: W]   = dist_w;
            pdata_next[2*W +: W]   = pt_clip[0][W-1:0];
            pdata_next[3*W +: W]   = pt_clip[1][W-1:0];
            pdata_next[4*W +: W]   = pt_clip[2][W-1:0];
            puser_next[USER_HIT]   = 1'b1;
            puser_next[USER_ENTER] = enter7_reg;
            puser_next[USER_SAT]   = any_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else if (en)
            pv_reg <= st7_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pdata_reg <= pdata_next;
            puser_reg <= puser_next;
        end
    end

    // ---------------- output register and skid slot ----------------
    logic                  out_v_reg;
    logic [OTD-1:0]        out_data_reg;
    logic [USER_BITS-1:0]  out_user_reg;
    logic                  skid_v_reg;
    logic [OTD-1:0]        skid_data_reg;
    logic [USER_BITS-1:0]  skid_user_reg;
    logic                  out_free;

    assign out_free = !out_v_reg || m_tready;
    assign en       = !skid_v_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
                out_v_reg <= pv_reg;
        end
        else if (!skid_v_reg && pv_reg)
            skid_v_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_v_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_user_reg <= skid_user_reg;
            end
            else
            begin
                out_data_reg <= pdata_reg;
                out_user_reg <= puser_reg;
            end
        end
        else if (!skid_v_reg)
        begin
            skid_data_reg <= pdata_reg;
            skid_user_reg <= puser_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

`default_nettype wire

### rtl/core/rusi_mul.sv
// two-lane unsigned multiplier, one operand slice per pipeline stage
`default_nettype none

module rusi_mul #(
    parameter int XW         = 64,
    parameter int YW         = 64,
    parameter int CHUNK_BITS = rusi_pkg::MUL_CHUNK,
    parameter int SIDE_BITS  = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [XW-1:0]        x0,
    input  logic [YW-1:0]        y0,
    input  logic [XW-1:0]        x1,
    input  logic [YW-1:0]        y1,
    input  logic [SIDE_BITS-1:0] in_side,
    output logic                 out_valid,
    output logic [XW+YW-1:0]     p0,
    output logic [XW+YW-1:0]     p1,
    output logic [SIDE_BITS-1:0] out_side
);

    localparam int NS = (YW + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int YP = NS * CHUNK_BITS;
    localparam int PW = XW + YP;

    typedef struct packed {
        logic [XW-1:0]        x0;
        logic [XW-1:0]        x1;
        logic [YP-1:0]        y0;
        logic [YP-1:0]        y1;
        logic [PW-1:0]        acc0;
        logic [PW-1:0]        acc1;
        logic [SIDE_BITS-1:0] side;
    } mstg_t;

    mstg_t stg_reg [NS];
    logic  vld_reg [NS];
    mstg_t head;

    // operands enter with empty accumulators
    always_comb
    begin
        head.x0   = x0;
        head.x1   = x1;
        head.y0   = YP'(y0);
        head.y1   = YP'(y1);
        head.acc0 = '0;
        head.acc1 = '0;
        head.side = in_side;
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_stg
        mstg_t                      src;
        mstg_t                      stg_next;
        logic                       src_v;
        logic [XW+CHUNK_BITS-1:0]   pp0;
        logic [XW+CHUNK_BITS-1:0]   pp1;

        if (g == 0)
        begin : g_first
            assign src   = head;
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src   = stg_reg[g-1];
            assign src_v = vld_reg[g-1];
        end

        // add one partial product per lane
        always_comb
        begin
            pp0           = src.x0 * src.y0[g*CHUNK_BITS +: CHUNK_BITS];
            pp1           = src.x1 * src.y1[g*CHUNK_BITS +: CHUNK_BITS];
            stg_next      = src;
            stg_next.acc0 = src.acc0 + (PW'(pp0) << (g * CHUNK_BITS));
            stg_next.acc1 = src.acc1 + (PW'(pp1) << (g * CHUNK_BITS));
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (en)
                vld_reg[g] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stg_reg[g] <= stg_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign p0        = stg_reg[NS-1].acc0[XW+YW-1:0];
    assign p1        = stg_reg[NS-1].acc1[XW+YW-1:0];
    assign out_side  = stg_reg[NS-1].side;

endmodule

`default_nettype wire

### rtl/core/rusi_sqrt.sv
// two-lane integer square root, one result bit per pipeline stage
`default_nettype none

module rusi_sqrt #(
    parameter int RW0       = 129,
    parameter int RW1       = 64,
    parameter int SIDE_BITS = 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [RW0-1:0]          rad0,
    input  logic [RW1-1:0]          rad1,
    input  logic [SIDE_BITS-1:0]    in_side,
    output logic                    out_valid,
    output logic [(RW0+1)/2-1:0]    root0,
    output logic [(RW1+1)/2-1:0]    root1,
    output logic [SIDE_BITS-1:0]    out_side
);

    localparam int QW0 = (RW0 + 1) / 2;
    localparam int QW1 = (RW1 + 1) / 2;
    localparam int CW0 = 2 * QW0 + 1;
    localparam int CW1 = 2 * QW1 + 1;

    typedef struct packed {
        logic [RW0-1:0]       rem0;
        logic [QW0-1:0]       root0;
        logic [RW1-1:0]       rem1;
        logic [QW1-1:0]       root1;
        logic [SIDE_BITS-1:0] side;
    } sstg_t;

    sstg_t stg_reg [QW0];
    logic  vld_reg [QW0];
    sstg_t head;

    always_comb
    begin
        head.rem0  = rad0;
        head.root0 = '0;
        head.rem1  = rad1;
        head.root1 = '0;
        head.side  = in_side;
    end

    for (genvar g = 0; g < QW0; g++)
    begin : g_stg
        localparam int J = QW0 - 1 - g;
        sstg_t          src;
        sstg_t          stg_next;
        logic           src_v;
        logic [CW0-1:0] trial0;
        logic [RW1-1:0] rem1_step;
        logic [QW1-1:0] root1_step;

        if (g == 0)
        begin : g_first
            assign src   = head;
            assign src_v = in_valid;
        end
        else
        begin : g_rest
            assign src   = stg_reg[g-1];
            assign src_v = vld_reg[g-1];
        end

        // narrow lane only works on its own low result bits
        if (J < QW1)
        begin : g_lane1
            logic [CW1-1:0] trial1;
            always_comb
            begin
                trial1     = (CW1'(src.root1) << (J + 1)) | (CW1'(1'b1) << (2 * J));
                rem1_step  = src.rem1;
                root1_step = src.root1;
                if (CW1'(src.rem1) >= trial1)
                begin
                    rem1_step     = src.rem1 - RW1'(trial1);
                    root1_step[J] = 1'b1;
                end
            end
        end
        else
        begin : g_hold1
            assign rem1_step  = src.rem1;
            assign root1_step = src.root1;
        end

        // try the next root bit against the remainder
        always_comb
        begin
            trial0         = (CW0'(src.root0) << (J + 1)) | (CW0'(1'b1) << (2 * J));
            stg_next       = src;
            stg_next.rem1  = rem1_step;
            stg_next.root1 = root1_step;
            if (CW0'(src.rem0) >= trial0)
            begin
                stg_next.rem0     = src.rem0 - RW0'(trial0);
                stg_next.root0[J] = 1'b1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (en)
                vld_reg[g] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stg_reg[g] <= stg_next;
        end
    end

    assign out_valid = vld_reg[QW0-1];
    assign root0     = stg_reg[QW0-1].root0;
    assign root1     = stg_reg[QW0-1].root1;
    assign out_side  = stg_reg[QW0-1].side;

endmodule

`default_nettype wire

### rtl/core/rusi_div.sv
// restoring divider with an overflow check stage, then one quotient bit per pipeline stage
`default_nettype none

module rusi_div #(
    parameter int NUMW      = 82,
    parameter int DENW      = 64,
    parameter int QB        = 31,
    parameter int SIDE_BITS = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NUMW-1:0]      num,
    input  logic [DENW-1:0]      den,
    input  logic [SIDE_BITS-1:0] in_side,
    output logic                 out_valid,
    output logic [QB-1:0]        quo,
    output logic                 ovf,
    output logic [SIDE_BITS-1:0] out_side
);

    localparam int NS = QB + 1;
    localparam int CW = ((NUMW > DENW + QB) ? NUMW : DENW + QB) + 1;

    typedef struct packed {
        logic [DENW-1:0]      d;
        logic [NUMW-1:0]      rem;
        logic [QB-1:0]        q;
        logic                 ovf;
        logic [SIDE_BITS-1:0] side;
    } dstg_t;

    dstg_t stg_reg [NS];
    logic  vld_reg [NS];
    dstg_t head;

    always_comb
    begin
        head.d    = den;
        head.rem  = num;
        head.q    = '0;
        head.ovf  = 1'b0;
        head.side = in_side;
    end

    for (genvar g = 0; g < NS; g++)
    begin : g_stg
        dstg_t src;
        dstg_t stg_next;
        logic  src_v;

        if (g == 0)
        begin : g_first
            assign src   = head;
            assign src_v = in_valid;

            // quotient does not fit in QB bits
            always_comb
            begin
                stg_next     = src;
                stg_next.ovf = CW'(src.rem) >= (CW'(src.d) << QB);
            end
        end
        else
        begin : g_rest
            localparam int J = QB - g;
            logic [CW-1:0] trial;

            assign src   = stg_reg[g-1];
            assign src_v = vld_reg[g-1];

            always_comb
            begin
                trial    = CW'(src.d) << J;
                stg_next = src;
                if (CW'(src.rem) >= trial)
                begin
                    stg_next.rem  = src.rem - NUMW'(trial);
                    stg_next.q[J] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[g] <= 1'b0;
            else if (en)
                vld_reg[g] <= src_v;
        end

        always_ff @(posedge clk)
        begin
            if (en)
                stg_reg[g] <= stg_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign quo       = stg_reg[NS-1].q;
    assign ovf       = stg_reg[NS-1].ovf;
    assign out_side  = stg_reg[NS-1].side;

endmodule

`default_nettype wire

### tb/tb_ray_unit_sphere_intersect.sv
// testbench for the ray and unit sphere intersection block
`default_nettype none

module tb_ray_unit_sphere_intersect;

    import rusi_pkg::*;

    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] NEG1 = 32'hFFFF_0000;
    localparam logic [31:0] TWO  = 32'h0002_0000;
    localparam logic [31:0] NEG2 = 32'hFFFE_0000;
    localparam logic [31:0] MAXW = 32'h7FFF_FFFF;
    localparam logic [31:0] MINW = 32'h8000_0000;
    localparam int N_RANDOM   = 1400;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        logic        hit;
        logic        entering;
        logic        saturated;
        logic [31:0] ray_param;
        logic [31:0] hit_distance;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] point_z;
    } isect_t;

    typedef struct packed {
        logic [191:0] ray;
        logic         typed;
        isect_t       want;
    } ray_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    // dir_x, dir_y, dir_z, org_x, org_y, org_z
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // ray_param, hit_distance, point_x, point_y, point_z
    logic [159:0] m_tdata;
    // hit, entering, saturated
    logic [USER_BITS-1:0] m_tuser;

    isect_t pending_hits[$];
    int     errors;
    int     idle_cycles;
    bit     steady;

    ray_unit_sphere_intersect dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // floor square root, result below 2^(top+1)
    function automatic logic [255:0] floor_sqrt(input logic [255:0] v, input int top);
        logic [255:0] res;
        logic [255:0] trial;
        res = '0;
        for (int i = top; i >= 0; i--)
        begin
            trial = res | (256'd1 << i);
            if (trial * trial <= v)
                res = trial;
        end
        return res;
    endfunction

    // clip to the signed 32 bit range
    function automatic logic [31:0] clip32(input logic signed [255:0] x, inout logic sat);
        logic signed [255:0] hi;
        logic signed [255:0] lo;
        hi = (256'sd1 <<< 31) - 1;
        lo = -(256'sd1 <<< 31);
        if (x > hi)
        begin
            sat = 1'b1;
            return MAXW;
        end
        if (x < lo)
        begin
            sat = 1'b1;
            return MINW;
        end
        return x[31:0];
    endfunction

    // nearest positive crossing of the ray with the unit sphere
    function automatic isect_t sphere_hit(input logic [191:0] ray);
        logic signed [255:0] k[3];
        logic signed [255:0] l[3];
        logic signed [255:0] a, b, c, disc, s, n1, n2, t, p;
        logic [31:0]         pt[3];
        isect_t              r;
        logic                sat;
        logic                enter;
        r = '0;
        sat = 1'b0;
        a = 0;
        b = 0;
        c = 0;
        for (int i = 0; i < 3; i++)
        begin
            k[i] = $signed(ray[32*i +: 32]);
            l[i] = $signed(ray[32*(i+3) +: 32]);
            a += k[i] * k[i];
            b += k[i] * l[i];
            c += l[i] * l[i];
        end
        c = c - (256'sd1 <<< 32);
        if (a == 0)
            return r;
        disc = b * b - a * c;
        if (disc < 0)
            return r;
        s = $signed(floor_sqrt(disc, 80));
        n1 = -b + s;
        n2 = -b - s;
        // smaller root first, it must be at least one lsb
        if (n2 > 0 && ((n2 <<< 16) / a) != 0)
        begin
            t = (n2 <<< 16) / a;
            enter = 1'b1;
        end
        else if (n1 > 0 && ((n1 <<< 16) / a) != 0)
        begin
            t = (n1 <<< 16) / a;
            enter = 1'b0;
        end
        else
            return r;
        r.ray_param = clip32(t, sat);
        t = $signed({224'd0, r.ray_param});
        for (int i = 0; i < 3; i++)
        begin
            p = ((k[i] * t) >>> 16) + l[i];
            pt[i] = clip32(p, sat);
        end
        p = $signed(floor_sqrt(a, 40));
        p = (t * p) >>> 16;
        r.hit_distance = clip32(p, sat);
        r.hit = 1'b1;
        r.entering = enter;
        r.point_x = pt[0];
        r.point_y = pt[1];
        r.point_z = pt[2];
        r.saturated = sat;
        return r;
    endfunction

    function automatic logic [191:0] pack_ray(input logic [31:0] dx, dy, dz, ox, oy, oz);
        return {oz, oy, ox, dz, dy, dx};
    endfunction

    function automatic isect_t typed_hit(input logic ent, input logic [31:0] t, d, px, py, pz);
        isect_t r;
        r = '{hit: 1'b1, entering: ent, saturated: 1'b0, ray_param: t, hit_distance: d,
              point_x: px, point_y: py, point_z: pz};
        return r;
    endfunction

    // random ray, mostly aimed near the sphere
    function automatic logic [191:0] random_ray();
        logic [31:0] d[3];
        logic [31:0] o[3];
        int          kind;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            if (kind < 2)
            begin
                d[i] = $urandom;
                o[i] = $urandom;
            end
            else if (kind == 2)
            begin
                d[i] = $urandom_range(0, 3) - 1;
                o[i] = $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            end
            else
            begin
                o[i] = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
                d[i] = -o[i] + ($signed($urandom_range(0, 32'h0002_0000)) - 32'sh0001_0000);
                if (kind == 9)
                    d[i] = d[i] <<< $urandom_range(0, 12);
            end
        end
        return pack_ray(d[0], d[1], d[2], o[0], o[1], o[2]);
    endfunction

    // receiver stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 12);
    end

    // result checker
    always @(posedge clk)
    begin
        isect_t want;
        isect_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{hit: m_tuser[USER_HIT], entering: m_tuser[USER_ENTER],
                    saturated: m_tuser[USER_SAT], ray_param: m_tdata[31:0],
                    hit_distance: m_tdata[63:32], point_x: m_tdata[95:64],
                    point_y: m_tdata[127:96], point_z: m_tdata[159:128]};
            if (pending_hits.size() == 0)
            begin
                $display("%0t: unexpected item, actual %p", $time, got);
                errors++;
            end
            else
            begin
                want = pending_hits.pop_front();
                if (got.hit !== want.hit || got.entering !== want.entering ||
                    got.saturated !== want.saturated || got.ray_param !== want.ray_param ||
                    got.hit_distance !== want.hit_distance || got.point_x !== want.point_x ||
                    got.point_y !== want.point_y || got.point_z !== want.point_z)
                begin
                    $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // send one ray and queue what it should give, valid stays up for the next one
    task automatic send_ray(input logic [191:0] ray, input logic typed, input isect_t want);
        if (!steady)
            while ($urandom_range(0, 99) < 12)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        s_tvalid <= 1'b1;
        s_tdata  <= ray;
        do
            @(posedge clk);
        while (!s_tready);
        pending_hits.push_back(typed ? want : sphere_hit(ray));
        @(negedge clk);
    endtask

    ray_row_t rows[$];

    initial
    begin
        isect_t none;
        none = '0;
        errors = 0;
        idle_cycles = 0;
        steady = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;

        // directed rays
        rows.push_back('{pack_ray(0, 0, 0, 0, 0, 0), 1'b1, none});
        rows.push_back('{pack_ray(0, 0, 0, MAXW, MINW, MAXW), 1'b1, none});
        rows.push_back('{pack_ray(0, 0, ONE, 0, 0, NEG2), 1'b1,
                         typed_hit(1'b1, ONE, ONE, 0, 0, NEG1)});
        rows.push_back('{pack_ray(0, 0, ONE, 0, 0, 0), 1'b1,
                         typed_hit(1'b0, ONE, ONE, 0, 0, ONE)});
        rows.push_back('{pack_ray(ONE, 0, 0, 0, 32'h0005_0000, 0), 1'b1, none});
        rows.push_back('{pack_ray(0, 0, ONE, 0, 0, TWO), 1'b1, none});
        rows.push_back('{pack_ray(ONE, 0, 0, NEG2, ONE, 0), 1'b0, none});
        rows.push_back('{pack_ray(0, 0, 1, 0, 0, NEG2), 1'b0, none});
        rows.push_back('{pack_ray(0, 0, MAXW, 0, 0, NEG2), 1'b0, none});
        rows.push_back('{pack_ray(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW), 1'b0, none});
        rows.push_back('{pack_ray(MINW, MINW, MINW, MINW, MINW, MINW), 1'b0, none});
        rows.push_back('{pack_ray(MAXW, MINW, MAXW, MINW, MAXW, MINW), 1'b0, none});
        rows.push_back('{pack_ray(MINW, MINW, MINW, MAXW, MAXW, MAXW), 1'b0, none});
        rows.push_back('{pack_ray(1, 1, 1, 0, 0, 0), 1'b0, none});
        rows.push_back('{pack_ray(32'hFFFF_FFFF, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{pack_ray(NEG1, NEG1, NEG1, ONE, ONE, ONE), 1'b0, none});
        rows.push_back('{pack_ray(1, 0, 0, 0, 0, 0), 1'b0, none});
        rows.push_back('{pack_ray(0, 32'h0000_8000, 0, 0, MINW, 0), 1'b0, none});

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_ray(rows[i].ray, rows[i].typed, rows[i].want);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            steady = (n >= 500 && n < 700);
            // let the pipeline drain completely once
            if (n == 900)
            begin
                s_tvalid <= 1'b0;
                while (pending_hits.size() != 0)
                    @(negedge clk);
            end
            send_ray(random_ray(), 1'b0, none);
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (pending_hits.size() != 0)
            @(negedge clk);
        repeat (200) @(negedge clk);

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
